// ----- design/box_fischer_burmeister_residual_assert.svh -----
// Assertion macros for the box Fischer-Burmeister residual block.
// Included by the top level; needs clk and rst_n in scope.
`ifndef BOX_FISCHER_BURMEISTER_RESIDUAL_ASSERT_SVH
`define BOX_FISCHER_BURMEISTER_RESIDUAL_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define BFB_ASSERT_IMPL(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BFB_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ----- design/bfb_pkg.sv -----
// Shared constants and types for the box Fischer-Burmeister residual block.
// No dependencies.
package bfb_pkg;
    localparam int DATA_W      = 32;
    localparam int MAG_W       = 33;  // magnitude of a 33-bit signed difference
    localparam int SQ_W        = 67;  // sum of two squared magnitudes
    localparam int ROOT_W      = 34;  // floor sqrt of SQ_W bits
    localparam int SUM_W       = 37;  // signed residual before clipping
    localparam int FRAC_BITS_D = 16;
endpackage

// ----- design/bfb_sqrt.sv -----
// Pipelined exact integer square root, one result bit per stage.
// Depends on bfb_pkg. Carries a side payload of width SIDE_W.
module bfb_sqrt
    import bfb_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] side_out
);
    localparam int N = ROOT_W;

    logic              v_reg    [N+1];
    logic [SQ_W-1:0]   rem_reg  [N+1];
    logic [ROOT_W-1:0] q_reg    [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = radicand;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
    end

    // Decide one root bit per stage, MSB first (restoring method)
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam int B = N - 1 - s;
        logic [SQ_W+1:0] trial;
        logic [SQ_W+1:0] rem_w;
        always_comb
        begin
            trial = ({{(SQ_W+2-ROOT_W){1'b0}}, q_reg[s]} << (B + 1))
                  | ((SQ_W+2)'(1) << (2 * B));
            rem_w = {2'b00, rem_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
                if (rem_w >= trial)
                begin
                    rem_reg[s+1] <= SQ_W'(rem_w - trial);
                    q_reg[s+1]   <= q_reg[s] | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    q_reg[s+1]   <= q_reg[s];
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root      = q_reg[N];
    assign side_out  = side_reg[N];
endmodule

// ----- design/bfb_front.sv -----
// Front stages: differences, case decode, magnitudes and squared sums.
// Depends on bfb_pkg.
module bfb_front
    import bfb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] f_value,
    input  logic signed [DATA_W-1:0] lower_bound,
    input  logic signed [DATA_W-1:0] upper_bound,
    input  logic                     last_in,
    output logic                     out_valid,
    output logic [SQ_W-1:0]          sq_lo,
    output logic [SQ_W-1:0]          sq_hi,
    output logic [SUM_W+3:0]         side
);
    // stage 1 registers
    logic                     v1_reg;
    logic signed [MAG_W-1:0]  dlo_reg, dhi_reg;
    logic signed [DATA_W-1:0] f1_reg;
    logic                     last1_reg;
    // stage 2 registers
    logic                     v2_reg;
    logic [2*MAG_W-1:0]       plo_reg, phi_reg, pf_reg;
    logic signed [MAG_W-1:0]  dlo2_reg, dhi2_reg;
    logic signed [DATA_W-1:0] f2_reg;
    logic                     last2_reg;
    // stage 3 registers
    logic                     v3_reg;
    logic [SQ_W-1:0]          slo_reg, shi_reg;
    logic [1:0]               mode_reg;
    logic                     fneg3_reg;
    logic signed [SUM_W-1:0]  base_reg;
    logic                     last3_reg;

    logic [MAG_W-1:0] mlo, mhi, mf;
    logic             fneg, ge_lo, le_hi;
    logic [1:0]       mode_next;
    logic signed [SUM_W-1:0] base_next;

    // Form differences against both bounds
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlo_reg   <= MAG_W'(x_value) - MAG_W'(lower_bound);
            dhi_reg   <= MAG_W'(x_value) - MAG_W'(upper_bound);
            f1_reg    <= f_value;
            last1_reg <= last_in;
        end
    end

    // Square the magnitudes
    always_comb
    begin
        mlo = dlo_reg[MAG_W-1] ? MAG_W'(-dlo_reg) : MAG_W'(dlo_reg);
        mhi = dhi_reg[MAG_W-1] ? MAG_W'(-dhi_reg) : MAG_W'(dhi_reg);
        mf  = f1_reg[DATA_W-1] ? MAG_W'(-MAG_W'(f1_reg)) : MAG_W'(f1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg   <= mlo * mlo;
            phi_reg   <= mhi * mhi;
            pf_reg    <= mf * mf;
            dlo2_reg  <= dlo_reg;
            dhi2_reg  <= dhi_reg;
            f2_reg    <= f1_reg;
            last2_reg <= last1_reg;
        end
    end

    // Decode the case and add the squares
    // mode: 0 = no root, 1 = one root plus f, 2 = two roots
    always_comb
    begin
        fneg  = f2_reg[DATA_W-1];
        ge_lo = !dlo2_reg[MAG_W-1];
        le_hi = dhi2_reg[MAG_W-1] || (dhi2_reg == '0);
        base_next = fneg ? SUM_W'(dhi2_reg) : SUM_W'(dlo2_reg);
        if (!fneg)
            mode_next = !ge_lo ? 2'd0 : (le_hi ? 2'd1 : 2'd2);
        else
            mode_next = !le_hi ? 2'd0 : (ge_lo ? 2'd1 : 2'd2);
        if (mode_next == 2'd1)
            base_next = base_next + SUM_W'(f2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slo_reg   <= SQ_W'(plo_reg) + SQ_W'(pf_reg);
            shi_reg   <= SQ_W'(phi_reg) + SQ_W'(pf_reg);
            mode_reg  <= mode_next;
            fneg3_reg <= fneg;
            base_reg  <= base_next;
            last3_reg <= last2_reg;
        end
    end

    // Track valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign sq_lo     = slo_reg;
    assign sq_hi     = shi_reg;
    // side: {last, fneg, mode, base}
    assign side      = {last3_reg, fneg3_reg, mode_reg, base_reg};
endmodule

// ----- design/box_fischer_burmeister_residual.sv -----
// Channel  Dir  Fields (tdata from bit 0)
// s_axis   in   x_value, f_value, lower_bound, upper_bound; tlast = last_in
// m_axis   out  box_residual, saturated (tdata[32]); tlast = last_out
// One item enters per cycle unless m_axis stalls; the pipe is 3 front stages + 34 root stages + 1 output.
// The 34-stage square root (one bit per stage) sets the depth.
// rst_n clears valid bits only. A stall on m_axis holds the whole pipe in place.
// Top level of the box Fischer-Burmeister residual; uses bfb_pkg, bfb_front,
// bfb_sqrt and the assertion header.
`include "box_fischer_burmeister_residual_assert.svh"
module box_fischer_burmeister_residual
    import bfb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_D
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // x_value, f_value, lower_bound, upper_bound
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // box_residual, saturated, zero fill
    output logic         m_axis_tlast
);
    localparam int SIDE_W = SUM_W + 4;

    logic en;
    logic fv, rv_lo, rv_hi;
    logic [SQ_W-1:0] sq_lo, sq_hi;
    logic [SIDE_W-1:0] side_f, side_lo;
    logic [ROOT_W-1:0] r_lo, r_hi;
    logic out_v_reg;
    logic [DATA_W-1:0] res_reg;
    logic sat_reg, last_reg;
    logic signed [SUM_W-1:0] base;
    logic [1:0] mode;
    logic fneg, fneg_hi;
    logic signed [SUM_W-1:0] ext_lo, ext_hi;
    logic signed [SUM_W-1:0] sum_v;

    // Advance everything unless the output holds an untaken transfer
    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    bfb_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .x_value(s_axis_tdata[31:0]), .f_value(s_axis_tdata[63:32]),
        .lower_bound(s_axis_tdata[95:64]), .upper_bound(s_axis_tdata[127:96]),
        .last_in(s_axis_tlast),
        .out_valid(fv), .sq_lo(sq_lo), .sq_hi(sq_hi), .side(side_f)
    );

    bfb_sqrt #(.SIDE_W(SIDE_W)) u_sqrt_lo (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fv), .radicand(sq_lo),
        .side_in(side_f), .out_valid(rv_lo), .root(r_lo), .side_out(side_lo)
    );

    bfb_sqrt #(.SIDE_W(1)) u_sqrt_hi (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(fv), .radicand(sq_hi),
        .side_in(side_f[SUM_W+2]), .out_valid(rv_hi), .root(r_hi),
        .side_out(fneg_hi)
    );

    // Combine roots by case; the sign of f picks the mirrored rule
    always_comb
    begin
        base   = side_lo[SUM_W-1:0];
        mode   = side_lo[SUM_W+1:SUM_W];
        fneg   = side_lo[SUM_W+2];
        ext_lo = SUM_W'(r_lo);
        ext_hi = SUM_W'(r_hi);
        unique case (mode)
            2'd1:    sum_v = fneg ? base + ext_hi : base - ext_lo;
            2'd2:    sum_v = fneg ? base + ext_hi - ext_lo : base - ext_lo + ext_hi;
            default: sum_v = base;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= rv_lo;
    end

    // Clip to 32 bits and hold the output transfer
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= side_lo[SUM_W+3];
            if (sum_v > SUM_W'(32'sh7FFFFFFF))
            begin
                res_reg <= 32'h7FFFFFFF;
                sat_reg <= 1'b1;
            end
            else if (sum_v < -SUM_W'(33'sh080000000))
            begin
                res_reg <= 32'h80000000;
                sat_reg <= 1'b1;
            end
            else
            begin
                res_reg <= sum_v[DATA_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {7'd0, sat_reg, res_reg};
    assign m_axis_tlast  = last_reg;

    `BFB_ASSERT_IMPL(a_roots_aligned, rv_lo, rv_hi)
    `BFB_ASSERT_IMPL(a_sign_aligned, rv_lo, fneg_hi == side_lo[SUM_W+2])
    `BFB_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BFB_ASSERT_IMPL(a_ready_tracks, m_axis_tready, s_axis_tready)
endmodule

// ----- dv/box_fischer_burmeister_residual_tb.sv -----
// Testbench for box_fischer_burmeister_residual: streams vector elements,
// predicts each residual with an exact wide-integer model and checks outputs.
// Depends on bfb_pkg and the block's RTL.
`timescale 1ns / 1ps

module box_fischer_burmeister_residual_tb;
    import bfb_pkg::*;

    // Expected result for one element
    typedef struct packed {
        logic signed [31:0] residual;
        logic               sat;
        logic               last;
    } residual_t;

    // Predicts residuals and matches them against the output stream
    class residual_scoreboard;
        residual_t pending[$];
        int        mismatches;

        // floor(sqrt(a*a + b*b)), exact on wide integers
        function logic [ROOT_W-1:0] hyp_root(logic signed [MAG_W:0] a,
                                             logic signed [MAG_W:0] b);
            logic [MAG_W-1:0]  ma;
            logic [MAG_W-1:0]  mb;
            logic [SQ_W-1:0]   sum;
            logic [ROOT_W-1:0] root;
            logic [ROOT_W-1:0] cand;
            ma = a < 0 ? MAG_W'(-a) : MAG_W'(a);
            mb = b < 0 ? MAG_W'(-b) : MAG_W'(b);
            sum = SQ_W'(ma) * SQ_W'(ma) + SQ_W'(mb) * SQ_W'(mb);
            root = '0;
            for (int bit_idx = ROOT_W - 1; bit_idx >= 0; bit_idx--)
            begin
                cand = root | (ROOT_W'(1) << bit_idx);
                if ((2 * SQ_W)'(cand) * (2 * SQ_W)'(cand) <= (2 * SQ_W)'(sum))
                    root = cand;
            end
            return root;
        endfunction

        // Note an accepted element and compute its residual
        function void note_element(logic signed [31:0] x, logic signed [31:0] f,
                                   logic signed [31:0] lo, logic signed [31:0] hi,
                                   logic last);
            logic signed [63:0] v;
            residual_t          r;
            if (f >= 0)
            begin
                v = 64'(x) - 64'(lo);
                if (x >= lo)
                begin
                    v -= 64'(hyp_root(34'(x) - 34'(lo), 34'(f)));
                    if (x <= hi)
                        v += 64'(f);
                    else
                        v += 64'(hyp_root(34'(x) - 34'(hi), 34'(f)));
                end
            end
            else
            begin
                v = 64'(x) - 64'(hi);
                if (x <= hi)
                begin
                    v += 64'(hyp_root(34'(x) - 34'(hi), 34'(f)));
                    if (x >= lo)
                        v += 64'(f);
                    else
                        v -= 64'(hyp_root(34'(x) - 34'(lo), 34'(f)));
                end
            end
            r.sat = 1'b0;
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                r.sat = 1'b1;
            end
            else if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                r.sat = 1'b1;
            end
            r.residual = v[31:0];
            r.last = last;
            pending.push_back(r);
        endfunction

        // Compare one output transfer with the oldest expectation
        function void check_result(logic signed [31:0] res, logic sat, logic last);
            residual_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: residual %0d sat %0b last %0b",
                             res, sat, last);
                return;
            end
            e = pending.pop_front();
            if (e.residual !== res || e.sat !== sat || e.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp residual %0d sat %0b last %0b, got %0d %0b %0b",
                             e.residual, e.sat, e.last, res, sat, last);
            end
        endfunction
    endclass

    localparam int LATENCY   = 40;
    localparam int RAND_ITEMS = 1650;
    localparam longint CYCLE_LIMIT = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // x_value, f_value, lower_bound, upper_bound
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;        // box_residual, saturated, zero fill
    logic         m_axis_tlast;

    residual_scoreboard sb = new();
    longint cycles = 0;
    bit     no_idle = 1'b0;
    bit     hold_off = 1'b0;

    box_fischer_burmeister_residual uut (.*);

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check output transfers
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tlast);

    // Receiver: random stalls, with one long hold-off
    always @(posedge clk)
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);

    // Offer one element and wait for its transfer
    task automatic send_element(logic [31:0] x, logic [31:0] f, logic [31:0] lo,
                                logic [31:0] hi, logic last);
        while (!no_idle && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hi, lo, f, x};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_element(x, f, lo, hi, last);
    endtask

    // Values biased toward edges and small magnitudes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(20000)) - 10000) <<< $urandom_range(16);
        endcase
    endfunction

    // Box, usually ordered, with the point at a bound, at its midpoint or at a random value
    task automatic send_random();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] t;
        logic signed [31:0] x;
        lo = pick_value();
        hi = pick_value();
        if ($urandom_range(9) != 0 && lo > hi)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        case ($urandom_range(3))
            0: x = lo;
            1: x = hi;
            2: x = lo + 32'((longint'(hi) - longint'(lo)) / 2);
            default: x = pick_value();
        endcase
        send_element(x, pick_value(), lo, hi, 1'($urandom_range(1)));
    endtask

    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONE  = 32'h00010000;

    initial
    begin
        int hold;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every case of both signs of f, extremes, inverted box
        no_idle = 1'b1;
        send_element(-ONE, ONE, 0, ONE, 1'b0);            // f >= 0, below box
        send_element(ONE / 2, ONE, 0, ONE, 1'b0);         // f >= 0, inside
        send_element(2 * ONE, ONE, 0, ONE, 1'b0);         // f >= 0, above
        send_element(2 * ONE, -ONE, 0, ONE, 1'b0);        // f < 0, above
        send_element(ONE / 2, -ONE, 0, ONE, 1'b0);        // f < 0, inside
        send_element(-ONE, -ONE, 0, ONE, 1'b1);           // f < 0, below
        send_element(0, 0, 0, 0, 1'b0);                   // all zero
        send_element(MAXV, MAXV, MINV, MINV, 1'b0);       // large positive, saturates
        send_element(MINV, MINV, MAXV, MAXV, 1'b1);       // large negative, saturates
        send_element(MAXV, MINV, MINV, MAXV, 1'b0);
        send_element(MINV, MAXV, MINV, MAXV, 1'b0);
        send_element(MAXV, MAXV, MAXV, MINV, 1'b0);       // inverted box
        send_element(0, ONE, ONE, -ONE, 1'b0);            // inverted box, f >= 0
        send_element(0, -ONE, ONE, -ONE, 1'b1);           // inverted box, f < 0
        send_element(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        send_element(MINV, 0, MINV, MINV, 1'b0);
        send_element(MAXV, MINV, MAXV, MAXV, 1'b1);
        no_idle = 1'b0;

        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                hold = 0;
                while (hold < 150)
                begin
                    @(posedge clk);
                    hold++;
                end
                hold_off = 1'b0;
            end
            begin
                no_idle = 1'b1;
                repeat (80) send_random();
                no_idle = 1'b0;
            end
        join

        // Random part, with one stretch free of idling
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            no_idle = (i >= 600 && i < 900);
            send_random();
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/bfb_pkg.sv
design/bfb_sqrt.sv
design/bfb_front.sv
design/box_fischer_burmeister_residual.sv
dv/box_fischer_burmeister_residual_tb.sv
